>>> sv/stsrch_pkg.sv
// Shared types, widths and register map of the edge trigger search block.
`default_nettype none

package stsrch_pkg;

  // Default geometry of the sample buffer.
  localparam int DEPTH_DEF       = 2048;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed widths of the ports and registers.
  localparam int SAMPLE_IN_W = 12;
  localparam int LEVEL_W     = 12;
  localparam int HWIN_W      = 11;
  localparam int IDX_W       = 11;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // Reset values of the configuration registers.
  localparam logic [LEVEL_W-1:0] LEVEL_RST   = 12'd2048;
  localparam logic               FALLING_RST = 1'b0;
  localparam logic [HWIN_W-1:0]  HWIN_RST    = 11'd64;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_TRIGGER_LEVEL = 2'd0;
  localparam logic [1:0] REG_FALLING_SLOPE = 2'd1;
  localparam logic [1:0] REG_HALF_WINDOW   = 2'd2;

  // Input command codes.
  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               falling;
    logic [HWIN_W-1:0]  half_window;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;      // write the sample at the next position
    logic load_hw;    // load the half window into the reduction register
    logic sub_hw;     // take one buffer depth off the half window
    logic set_start;  // compute the start position and aim the read there
    logic read_step;  // move the read address one position older
    logic prime;      // latch the start sample as the current sample
    logic walk;       // test one position for a crossing
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hw_big;     // half window still at or above the depth
    logic hit;        // crossing at the current position
    logic last;       // current position is the last of the window
  } dp_status_t;

endpackage

`default_nettype wire

>>> sv/stsrch_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module stsrch_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/stsrch_regs.sv
// APB configuration registers: trigger level, slope select and half window.
`default_nettype none

module stsrch_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel_i,
  input  wire logic                           penable_i,
  input  wire logic                           pwrite_i,
  input  wire logic [stsrch_pkg::PADDR_W-1:0] paddr_i,
  input  wire logic [stsrch_pkg::PDATA_W-1:0] pwdata_i,
  output logic      [stsrch_pkg::PDATA_W-1:0] prdata_o,
  output logic                                pready_o,
  output stsrch_pkg::cfg_t                    cfg_o
);
  import stsrch_pkg::*;

  logic [LEVEL_W-1:0] level_q;
  logic               falling_q;
  logic [HWIN_W-1:0]  hwin_q;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign reg_idx  = paddr_i[3:2];

  // Register writes; an address beyond the map is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= LEVEL_RST;
      falling_q <= FALLING_RST;
      hwin_q    <= HWIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TRIGGER_LEVEL: level_q   <= pwdata_i[LEVEL_W-1:0];
        REG_FALLING_SLOPE: falling_q <= pwdata_i[0];
        REG_HALF_WINDOW:   hwin_q    <= pwdata_i[HWIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_TRIGGER_LEVEL: prdata_o = PDATA_W'(level_q);
      REG_FALLING_SLOPE: prdata_o = PDATA_W'(falling_q);
      REG_HALF_WINDOW:   prdata_o = PDATA_W'(hwin_q);
      default:           prdata_o = '0;
    endcase
  end

  assign cfg_o.level       = level_q;
  assign cfg_o.falling     = falling_q;
  assign cfg_o.half_window = hwin_q;

endmodule

`default_nettype wire

>>> sv/stsrch_ctrl.sv
// Controller of the trigger search: intake, window reduction and buffer walk.
`default_nettype none

module stsrch_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   cmd_i,
  input  wire stsrch_pkg::dp_status_t status_i,
  output stsrch_pkg::ctrl_cmd_t       cmd_o,
  output logic                        busy_o
);
  import stsrch_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ISSUE,
    ST_PRIME,
    ST_WALK
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && (state_q == ST_IDLE);

  // Next state and per-cycle commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_SEARCH) begin
            cmd_o.load_hw = 1'b1;
            state_d       = ST_REDUCE;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      ST_REDUCE: begin
        if (status_i.hw_big) begin
          cmd_o.sub_hw = 1'b1;
        end else begin
          cmd_o.set_start = 1'b1;
          state_d         = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.read_step = 1'b1;
        state_d         = ST_PRIME;
      end
      ST_PRIME: begin
        cmd_o.read_step = 1'b1;
        cmd_o.prime     = 1'b1;
        state_d         = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.hit || status_i.last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.read_step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/stsrch_dp.sv
// Datapath: sample buffer, write pointer, window reduction and crossing test.
`default_nettype none

module stsrch_dp #(
  parameter int DEPTH       = stsrch_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = stsrch_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire stsrch_pkg::cfg_t                   cfg_i,
  input  wire stsrch_pkg::ctrl_cmd_t              cmd_i,
  input  wire logic [stsrch_pkg::SAMPLE_IN_W-1:0] sample_i,
  output stsrch_pkg::dp_status_t                  status_o,
  output logic                                    result_valid_o,
  output logic      [stsrch_pkg::IDX_W-1:0]       trigger_index_o,
  output logic                                    found_o
);
  import stsrch_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = AW + 1;
  localparam int CW    = (AW + 1 > HWIN_W) ? AW + 1 : HWIN_W;
  localparam int HALF  = DEPTH / 2;
  localparam int CNTW  = $clog2(HALF);
  localparam int CMPW  = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

  logic [AW-1:0]          newest_q, newest_next;
  logic [FW-1:0]          fill_q;
  logic [CW-1:0]          hw_rem_q;
  logic [AW-1:0]          hw_lo;
  logic [AW-1:0]          start_q, start_calc;
  logic [AW-1:0]          rd_addr_q;
  logic [AW-1:0]          pos_q;
  logic [CNTW-1:0]        cnt_q;
  logic [SAMPLE_BITS-1:0] cur_q;
  logic                   rd_valid_q;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [SAMPLE_BITS-1:0] rd_value;
  logic [CMPW-1:0]        cur_ext, old_ext, lvl_ext;
  logic                   hit;
  logic                   last;
  logic                   res_valid_q;
  logic [IDX_W-1:0]       res_idx_q;
  logic                   res_found_q;

  // One position older, wrapping at the bottom of the buffer.
  function automatic logic [AW-1:0] back_one(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  assign newest_next = (newest_q == AW'(DEPTH - 1)) ? '0 : newest_q + 1'b1;

  // Start position: newest minus the reduced half window, modulo the depth.
  assign hw_lo      = AW'(hw_rem_q);
  assign start_calc = (newest_q >= hw_lo) ? newest_q - hw_lo
                    : AW'(FW'(newest_q) + FW'(DEPTH) - FW'(hw_lo));

  stsrch_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(newest_next),
    .wdata_i(SAMPLE_BITS'(sample_i)),
    .raddr_i(rd_addr_q),
    .rdata_o(rdata)
  );

  // Entries not yet written since reset read as zero.
  assign rd_value = rd_valid_q ? rdata : '0;

  // Crossing test between the current sample and the next older one.
  assign cur_ext = CMPW'(cur_q);
  assign old_ext = CMPW'(rd_value);
  assign lvl_ext = CMPW'(cfg_i.level);
  assign hit     = cfg_i.falling ? ((cur_ext <  lvl_ext) && (old_ext >= lvl_ext))
                                 : ((cur_ext >= lvl_ext) && (old_ext <  lvl_ext));
  assign last    = (cnt_q == CNTW'(HALF - 1));

  assign status_o.hw_big = (hw_rem_q >= CW'(DEPTH));
  assign status_o.hit    = hit;
  assign status_o.last   = last;

  // Write pointer, fill count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q    <= AW'(DEPTH - 1);
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.walk && (hit || last);
      if (cmd_i.store) begin
        newest_q <= newest_next;
        if (fill_q != FW'(DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // Search registers.
  always_ff @(posedge clk_i) begin
    rd_valid_q <= (FW'(rd_addr_q) < fill_q);
    if (cmd_i.load_hw) begin
      hw_rem_q <= CW'(cfg_i.half_window);
    end else if (cmd_i.sub_hw) begin
      hw_rem_q <= hw_rem_q - CW'(DEPTH);
    end
    if (cmd_i.set_start) begin
      start_q   <= start_calc;
      rd_addr_q <= start_calc;
    end else if (cmd_i.read_step) begin
      rd_addr_q <= back_one(rd_addr_q);
    end
    if (cmd_i.prime) begin
      cur_q <= rd_value;
      pos_q <= start_q;
      cnt_q <= '0;
    end else if (cmd_i.walk) begin
      cur_q <= rd_value;
      pos_q <= back_one(pos_q);
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.walk && hit) begin
      res_idx_q   <= IDX_W'(pos_q);
      res_found_q <= 1'b1;
    end else if (cmd_i.walk && last) begin
      res_idx_q   <= IDX_W'(start_q);
      res_found_q <= 1'b0;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign trigger_index_o = res_idx_q;
  assign found_o         = res_found_q;

endmodule

`default_nettype wire

>>> sv/scope_edge_trigger_search_core.sv
// Top level of the oscilloscope edge trigger search over a circular sample buffer.
//
// Usage: a transaction is taken at a rising edge with start high and busy low.
// cmd_i = 0 stores sample_i at the next buffer position and gives
// no result; stores may follow each other in every cycle.
// cmd_i = 1 runs a search. busy stays high through the reduce, issue, prime and
// walk states; reduce takes DEPTH off the half window, one subtract per cycle,
// and the walk tests K positions, K from 1 to DEPTH/2. The walk reads the sample
// memory through its single read port, one position per cycle. The result
// (trigger_index_o, found_o) is marked by result_valid_o for one cycle, in the
// first cycle with busy low; a new transaction may be taken in that same cycle.
// The receiver cannot stall: results must be taken when shown.
// Configuration goes through the APB port (trigger level at 0x0, slope at 0x4, half
// window at 0x8); the user must write it only while the block is idle (not enforced).
// Reset sets the newest position to DEPTH - 1 and the registers to their
// defaults; a fill count makes unwritten buffer entries read as zero, so no
// clearing pass is needed and the block is ready right after reset.
`default_nettype none

module scope_edge_trigger_search_core #(
  parameter int DEPTH       = stsrch_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = stsrch_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Command channel.
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               cmd_i,
  input  wire logic [stsrch_pkg::SAMPLE_IN_W-1:0] sample_i,
  // Result channel.
  output logic                                    result_valid_o,
  output logic      [stsrch_pkg::IDX_W-1:0]       trigger_index_o,
  output logic                                    found_o,
  // Configuration port.
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [stsrch_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [stsrch_pkg::PDATA_W-1:0]     pwdata,
  output logic      [stsrch_pkg::PDATA_W-1:0]     prdata,
  output logic                                    pready
);
  import stsrch_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  stsrch_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_o (prdata),
    .pready_o (pready),
    .cfg_o    (cfg)
  );

  stsrch_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .status_i(dp_status),
    .cmd_o   (ctrl_cmd),
    .busy_o  (busy)
  );

  stsrch_dp #(
    .DEPTH      (DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (ctrl_cmd),
    .sample_i       (sample_i),
    .status_o       (dp_status),
    .result_valid_o (result_valid_o),
    .trigger_index_o(trigger_index_o),
    .found_o        (found_o)
  );

`ifndef SYNTH
  // A result only follows a cycle in which a search was running.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a running search");

  // Each search gives a single one-cycle strobe.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // A store transaction never blocks intake.
  a_store_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_STORE)) |=> !busy)
    else $error("store transaction made the block busy");

  // A search transaction makes the block busy with no result yet.
  a_search_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_SEARCH)) |=> (busy && !result_valid_o))
    else $error("search transaction did not start a walk");
`endif

endmodule

`default_nettype wire
